@@ rtl/core/fed_pkg.sv @@
`timescale 1ns / 1ps
// fed_pkg: shared types, constants and helpers for the feedback echo delay.
// No dependencies.
package fed_pkg;

	localparam int LINE_DEPTH = 16384;
	localparam int LINE_AW = $clog2(LINE_DEPTH);
	localparam int FILL_W = LINE_AW + 1;
	localparam int DELAY_W = 14;
	localparam int GAIN_W = 8;
	localparam int SAMPLE_W = 16;
	localparam int DLY_CMP_W = (FILL_W > DELAY_W) ? FILL_W : DELAY_W;
	localparam int APB_AW = 4;
	localparam int APB_DW = 32;

	localparam logic [DELAY_W-1:0] DELAY_RESET = 14'd0;
	localparam logic [GAIN_W-1:0] GAIN_RESET = 8'd51;
	localparam logic LOWPASS_RESET = 1'b1;

	// ceil(2^17 / 3): exact truncating divide by 3 for magnitudes below 2^17
	localparam logic [16:0] RECIP3 = 17'd43691;

	typedef enum logic [1:0] {
		REG_DELAY   = 2'd0,
		REG_GAIN    = 2'd1,
		REG_LOWPASS = 2'd2
	} fed_reg_t;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] left_in;
		logic signed [SAMPLE_W-1:0] right_in;
	} fed_in_t;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] left_out;
		logic signed [SAMPLE_W-1:0] right_out;
	} fed_out_t;

	function automatic logic signed [SAMPLE_W-1:0] sat16(input logic signed [17:0] x);
		logic signed [SAMPLE_W-1:0] r;
		if (x > 18'sd32767) begin
			r = 16'sh7fff;
		end else if (x < -18'sd32768) begin
			r = 16'sh8000;
		end else begin
			r = x[SAMPLE_W-1:0];
		end
		return r;
	endfunction

endpackage

@@ rtl/core/feedback_echo_delay.sv @@
`timescale 1ns / 1ps
// feedback_echo_delay: mono feedback echo on a stereo stream, line held in one RAM.
// Depends on fed_pkg and fed_ram.
//
// Stages: an accepted input passes registers s1, s2, s3, s4 and the output register.
// Throughput: one transaction per cycle for a delay of 0 or >= 4, output not stalled.
//   For a delay d of 1..3 the read would hit a line write still in the pipe, so the
//   input waits until that write reaches s4 (line RAM read-modify-write loop).
// Reset: registers to delay 0, gain 51, lowpass on; no clearing pass. A fill
//   count tracks line entries written since reset or the last delay write, and
//   older entries read as zero.
module feedback_echo_delay
	import fed_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	// input sample stream
	input  logic              src_valid,
	output logic              src_ready,
	input  fed_in_t           src_data,
	// output sample stream
	output logic              dst_valid,
	input  logic              dst_ready,
	output fed_out_t          dst_data,
	// register port
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [APB_AW-1:0] paddr,
	input  logic [APB_DW-1:0] pwdata,
	output logic [APB_DW-1:0] prdata,
	output logic              pready
);

	// ------------------------------------------------------------------
	// Registers
	// ------------------------------------------------------------------
	logic [DELAY_W-1:0] delay_q;
	logic [GAIN_W-1:0]  gain_q;
	logic               lowpass_q;
	fed_reg_t           reg_sel;
	logic               cfg_wr;
	logic               delay_wr;

	assign pready   = 1'b1;
	assign cfg_wr   = psel && penable && pwrite;
	assign reg_sel  = fed_reg_t'(paddr[3:2]);
	assign delay_wr = cfg_wr && (reg_sel == REG_DELAY);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delay_q   <= DELAY_RESET;
			gain_q    <= GAIN_RESET;
			lowpass_q <= LOWPASS_RESET;
		end else if (cfg_wr) begin
			case (reg_sel)
				REG_DELAY:   delay_q   <= pwdata[DELAY_W-1:0];
				REG_GAIN:    gain_q    <= pwdata[GAIN_W-1:0];
				REG_LOWPASS: lowpass_q <= pwdata[0];
				default:     ;
			endcase
		end
	end

	always_comb begin
		case (reg_sel)
			REG_DELAY:   prdata = APB_DW'(delay_q);
			REG_GAIN:    prdata = APB_DW'(gain_q);
			REG_LOWPASS: prdata = APB_DW'(lowpass_q);
			default:     prdata = '0;
		endcase
	end

	// ------------------------------------------------------------------
	// Line addressing: write index, fill count, read address
	// ------------------------------------------------------------------
	logic [LINE_AW-1:0]   wr_idx_q;
	logic [FILL_W-1:0]    fill_q;
	logic [DLY_CMP_W-1:0] delay_ext;
	logic [FILL_W-1:0]    delay_sat;
	logic [FILL_W-1:0]    wr_ext;
	logic [FILL_W-1:0]    rd_sum;
	logic [LINE_AW-1:0]   rd_addr;
	logic                 rd_ok;
	logic                 active;

	assign active    = (delay_q != '0);
	assign delay_ext = DLY_CMP_W'(delay_q);
	// delay longer than the line reads the entry about to be overwritten
	assign delay_sat = (delay_ext > DLY_CMP_W'(LINE_DEPTH)) ? FILL_W'(LINE_DEPTH)
	                                                        : FILL_W'(delay_ext);
	assign wr_ext    = FILL_W'(wr_idx_q);
	assign rd_sum    = (wr_ext >= delay_sat) ? (wr_ext - delay_sat)
	                                         : (wr_ext + FILL_W'(LINE_DEPTH) - delay_sat);
	assign rd_addr   = rd_sum[LINE_AW-1:0];
	// entry written since the last clear, else it reads as zero
	assign rd_ok     = (fill_q >= delay_sat);

	// ------------------------------------------------------------------
	// Pipeline control
	// ------------------------------------------------------------------
	logic v_s1, v_s2, v_s3, v_s4;
	logic wr_s1, wr_s2, wr_s3, wr_s4;
	logic [LINE_AW-1:0] w_s1, w_s2, w_s3, w_s4;
	logic dst_valid_q;
	logic adv;
	logic hazard;
	logic fire;
	logic mem_we;
	logic fwd_hit;

	assign adv = !dst_valid_q || dst_ready;

	// a line write still in s1..s3 to the entry being read: hold the input
	assign hazard = active && (
		(v_s1 && wr_s1 && (w_s1 == rd_addr)) ||
		(v_s2 && wr_s2 && (w_s2 == rd_addr)) ||
		(v_s3 && wr_s3 && (w_s3 == rd_addr)));

	assign src_ready = adv && !hazard;
	assign fire      = src_valid && src_ready;
	assign mem_we    = adv && v_s4 && wr_s4;
	// s4 writes the entry being read at this edge: forward the write data
	assign fwd_hit   = mem_we && (w_s4 == rd_addr);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_idx_q <= '0;
			fill_q   <= '0;
		end else if (delay_wr) begin
			wr_idx_q <= '0;
			fill_q   <= '0;
		end else if (fire && active) begin
			wr_idx_q <= (wr_idx_q == LINE_AW'(LINE_DEPTH - 1)) ? '0 : wr_idx_q + 1'b1;
			if (fill_q != FILL_W'(LINE_DEPTH)) begin
				fill_q <= fill_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			v_s4        <= 1'b0;
			dst_valid_q <= 1'b0;
		end else if (adv) begin
			v_s1        <= fire;
			v_s2        <= v_s1;
			v_s3        <= v_s2;
			v_s4        <= v_s3;
			dst_valid_q <= v_s4;
		end
	end

	// ------------------------------------------------------------------
	// Line memory
	// ------------------------------------------------------------------
	logic [SAMPLE_W-1:0]        ram_rdata;
	logic signed [SAMPLE_W-1:0] stored_s4c;

	fed_ram #(
		.WIDTH(SAMPLE_W),
		.DEPTH(LINE_DEPTH)
	) u_line (
		.clk   (clk),
		.we    (mem_we),
		.waddr (w_s4),
		.wdata (stored_s4c),
		.re    (fire && active),
		.raddr (rd_addr),
		.rdata (ram_rdata)
	);

	// ------------------------------------------------------------------
	// Stage 1: echo sample arrives, feedback product, channel average
	// ------------------------------------------------------------------
	logic                       ok_s1;
	logic                       fwd_s1;
	logic signed [SAMPLE_W-1:0] fwd_data_s1;
	logic signed [SAMPLE_W-1:0] left_s1, right_s1;
	logic signed [SAMPLE_W-1:0] echo_s1;
	logic signed [16:0]         pair_sum_s1;
	logic signed [24:0]         gain_prod_s1;
	logic                       nz_s1;

	always_ff @(posedge clk) begin
		if (adv) begin
			ok_s1       <= rd_ok;
			fwd_s1      <= fwd_hit;
			fwd_data_s1 <= stored_s4c;
			wr_s1       <= active;
			w_s1        <= wr_idx_q;
			left_s1     <= src_data.left_in;
			right_s1    <= src_data.right_in;
		end
	end

	assign echo_s1      = !ok_s1 ? '0 : (fwd_s1 ? fwd_data_s1 : $signed(ram_rdata));
	assign nz_s1        = (echo_s1 != '0) || (left_s1 != '0) || (right_s1 != '0);
	assign pair_sum_s1  = 17'(left_s1) + 17'(right_s1);
	assign gain_prod_s1 = $signed({1'b0, gain_q}) * echo_s1;

	// ------------------------------------------------------------------
	// Stage 2: mix, saturate, lowpass sum and history
	// ------------------------------------------------------------------
	logic signed [SAMPLE_W-1:0] half_s2;
	logic signed [16:0]         fb_s2;
	logic                       nz_s2;
	logic signed [SAMPLE_W-1:0] left_s2, right_s2;
	logic signed [17:0]         mix_s2;
	logic signed [SAMPLE_W-1:0] val_s2c;
	logic signed [17:0]         sum3_s2c;
	logic signed [SAMPLE_W-1:0] hist_older_q, hist_newer_q;

	always_ff @(posedge clk) begin
		if (adv) begin
			half_s2  <= pair_sum_s1[16:1];
			fb_s2    <= gain_prod_s1[24:8];
			nz_s2    <= nz_s1;
			wr_s2    <= wr_s1;
			w_s2     <= w_s1;
			left_s2  <= left_s1;
			right_s2 <= right_s1;
		end
	end

	assign mix_s2   = 18'(half_s2) + 18'(fb_s2);
	assign val_s2c  = sat16(mix_s2);
	assign sum3_s2c = 18'(hist_older_q) + 18'(hist_newer_q) + 18'(val_s2c);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hist_older_q <= '0;
			hist_newer_q <= '0;
		end else if (delay_wr) begin
			hist_older_q <= '0;
			hist_newer_q <= '0;
		end else if (adv && v_s2 && wr_s2) begin
			if (!nz_s2) begin
				// silent step clears the filter
				hist_older_q <= '0;
				hist_newer_q <= '0;
			end else if (lowpass_q) begin
				hist_older_q <= hist_newer_q;
				hist_newer_q <= val_s2c;
			end
		end
	end

	// ------------------------------------------------------------------
	// Stage 3: divide by 3 as reciprocal multiply on the magnitude
	// ------------------------------------------------------------------
	logic signed [17:0]         sum3_s3;
	logic signed [SAMPLE_W-1:0] val_s3;
	logic                       nz_s3;
	logic signed [SAMPLE_W-1:0] left_s3, right_s3;
	logic [16:0]                mag_s3c;
	logic [33:0]                quot_prod_s3c;

	always_ff @(posedge clk) begin
		if (adv) begin
			sum3_s3  <= sum3_s2c;
			val_s3   <= val_s2c;
			nz_s3    <= nz_s2;
			wr_s3    <= wr_s2;
			w_s3     <= w_s2;
			left_s3  <= left_s2;
			right_s3 <= right_s2;
		end
	end

	assign mag_s3c       = 17'(sum3_s3[17] ? -sum3_s3 : sum3_s3);
	assign quot_prod_s3c = mag_s3c * RECIP3;

	// ------------------------------------------------------------------
	// Stage 4: restore sign, write the line, add a quarter to each channel
	// ------------------------------------------------------------------
	logic [16:0]                q_s4;
	logic                       neg_s4;
	logic signed [SAMPLE_W-1:0] val_s4;
	logic                       nz_s4;
	logic signed [SAMPLE_W-1:0] left_s4, right_s4;
	logic [16:0]                q_signed_s4c;
	logic signed [SAMPLE_W-1:0] quot_s4c;
	logic signed [SAMPLE_W-1:0] quarter_s4c;
	fed_out_t                   result_s4c;
	fed_out_t                   dst_data_q;

	always_ff @(posedge clk) begin
		if (adv) begin
			q_s4     <= quot_prod_s3c[33:17];
			neg_s4   <= sum3_s3[17];
			val_s4   <= val_s3;
			nz_s4    <= nz_s3;
			wr_s4    <= wr_s3;
			w_s4     <= w_s3;
			left_s4  <= left_s3;
			right_s4 <= right_s3;
		end
	end

	assign q_signed_s4c = neg_s4 ? (17'd0 - q_s4) : q_s4;
	assign quot_s4c     = $signed(q_signed_s4c[SAMPLE_W-1:0]);
	assign stored_s4c   = !nz_s4 ? '0 : (lowpass_q ? quot_s4c : val_s4);
	assign quarter_s4c  = stored_s4c >>> 2;

	always_comb begin
		if (wr_s4) begin
			result_s4c.left_out  = sat16(18'(quarter_s4c) + 18'(left_s4));
			result_s4c.right_out = sat16(18'(quarter_s4c) + 18'(right_s4));
		end else begin
			// bypass: pass the pair through untouched
			result_s4c.left_out  = left_s4;
			result_s4c.right_out = right_s4;
		end
	end

	// output register, parts the output handshake from the pipeline
	always_ff @(posedge clk) begin
		if (adv) begin
			dst_data_q <= result_s4c;
		end
	end

	assign dst_valid = dst_valid_q;
	assign dst_data  = dst_data_q;

	// ------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FILL_W'(LINE_DEPTH))
		else $error("fill count beyond line depth");

	a_idx_step: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && active && !delay_wr) |=>
		(wr_idx_q == (($past(wr_idx_q) == LINE_AW'(LINE_DEPTH - 1)) ? '0
		                                                        : $past(wr_idx_q) + 1'b1)))
		else $error("write index did not advance by one");

	a_hist_clear: assert property (@(posedge clk) disable iff (!arst_n)
		delay_wr |=> (hist_older_q == '0) && (hist_newer_q == '0))
		else $error("lowpass history not cleared on delay write");

	a_out_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(dst_valid_q) |-> $past(v_s4))
		else $error("output valid without a stage 4 transaction");

endmodule

@@ rtl/core/fed_ram.sv @@
`timescale 1ns / 1ps
// fed_ram: generic single-write, single-read RAM with registered read data.
// No dependencies; read-first when both ports hit the same entry.
module fed_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 256,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

@@ test/feedback_echo_delay_test.sv @@
`timescale 1ns / 1ps
// feedback_echo_delay_test: self-checking bench for the feedback echo delay block.
// Depends on fed_pkg and the feedback_echo_delay RTL; a scoreboard class tracks the echo line.
module feedback_echo_delay_test
	import fed_pkg::*;
();

	localparam int SAMPLE_MAX = 32767;
	localparam int SAMPLE_MIN = -32768;
	localparam int PIPE_SETTLE = 8;     // extra idle margin once the pipe has drained
	localparam int HOLD_CYCLES = 400;   // long receiver stall to back the pipe up
	localparam int STALL_LIMIT = 3000;  // watchdog: cycles without any transaction
	localparam int RANDOM_PHASES = 9;
	localparam int PHASE_PAIRS = 200;

	// Tracks the echo line, history taps and registers; predicts each output pair.
	class echo_tracker;
		logic signed [SAMPLE_W-1:0] line_mem [LINE_DEPTH];
		int wr_ptr;
		int tap_old;
		int tap_new;
		logic [DELAY_W-1:0] dly_reg;
		logic [GAIN_W-1:0] gain_reg;
		logic lp_reg;
		fed_out_t expected_pairs[$];
		int errors;
		int checked;
		int zero_steps;

		function new();
			errors = 0;
			checked = 0;
			zero_steps = 0;
			dly_reg = DELAY_RESET;
			gain_reg = GAIN_RESET;
			lp_reg = LOWPASS_RESET;
			clear_line();
		endfunction

		function void clear_line();
			foreach (line_mem[i])
				line_mem[i] = '0;
			wr_ptr = 0;
			tap_old = 0;
			tap_new = 0;
		endfunction

		function logic signed [SAMPLE_W-1:0] clip16(int x);
			if (x > SAMPLE_MAX)
				return 16'sh7fff;
			if (x < SAMPLE_MIN)
				return 16'sh8000;
			return x[SAMPLE_W-1:0];
		endfunction

		// register write as seen by the block; unknown indexes are dropped
		function void set_reg(logic [1:0] idx, logic [APB_DW-1:0] data);
			case (idx)
				REG_DELAY: begin
					dly_reg = data[DELAY_W-1:0];
					clear_line();
				end
				REG_GAIN: gain_reg = data[GAIN_W-1:0];
				REG_LOWPASS: lp_reg = data[0];
				default: ;
			endcase
		endfunction

		function fed_out_t mix_pair(fed_in_t item);
			int l, r, echo, val, stored, ridx;
			fed_out_t o;
			l = item.left_in;
			r = item.right_in;
			o.left_out = item.left_in;
			o.right_out = item.right_in;
			if (dly_reg != 0) begin
				ridx = (wr_ptr + LINE_DEPTH - int'(dly_reg)) % LINE_DEPTH;
				echo = line_mem[ridx];
				if (echo != 0 || l != 0 || r != 0) begin
					val = clip16(((l + r) >>> 1) + ((int'(gain_reg) * echo) >>> 8));
					if (lp_reg) begin
						stored = (tap_old + tap_new + val) / 3;
						tap_old = tap_new;
						tap_new = val;
					end else begin
						stored = val;
					end
					line_mem[wr_ptr] = stored[SAMPLE_W-1:0];
					o.left_out = clip16((stored >>> 2) + l);
					o.right_out = clip16((stored >>> 2) + r);
				end else begin
					// silence in and silence on the line
					tap_old = 0;
					tap_new = 0;
					line_mem[wr_ptr] = '0;
					zero_steps++;
				end
				wr_ptr = (wr_ptr + 1) % LINE_DEPTH;
			end
			return o;
		endfunction

		function void take_pair(fed_in_t item);
			expected_pairs.push_back(mix_pair(item));
		endfunction

		function void check_pair(fed_out_t got);
			fed_out_t want;
			if (expected_pairs.size() == 0) begin
				$error("output transaction with nothing expected: left %0d right %0d",
					got.left_out, got.right_out);
				errors++;
				return;
			end
			want = expected_pairs.pop_front();
			checked++;
			if (got.left_out !== want.left_out) begin
				$error("left_out expected %0d actual %0d", want.left_out, got.left_out);
				errors++;
			end
			if (got.right_out !== want.right_out) begin
				$error("right_out expected %0d actual %0d", want.right_out, got.right_out);
				errors++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic src_valid;
	logic src_ready;
	fed_in_t src_data;
	logic dst_valid;
	logic dst_ready;
	fed_out_t dst_data;
	logic psel;
	logic penable;
	logic pwrite;
	logic [APB_AW-1:0] paddr;
	logic [APB_DW-1:0] pwdata;
	logic [APB_DW-1:0] prdata;
	logic pready;

	echo_tracker tracker;
	int src_gap_pct;     // chance in percent of a sender gap before a transaction
	int snk_gap_pct;     // chance in percent of a receiver stall burst
	bit hold_req;        // asks the receiver for one long stall
	int reg_errors;
	int settings_applied;
	int stall_count;

	feedback_echo_delay DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.src_valid(src_valid),
		.src_ready(src_ready),
		.src_data (src_data),
		.dst_valid(dst_valid),
		.dst_ready(dst_ready),
		.dst_data (dst_data),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	initial clk = 1'b0;
	always #1 clk = ~clk;

	// Output side: every accepted transaction is checked against the oldest prediction.
	// Sampling right after the edge sees the values the block presented in that cycle.
	always @(posedge clk) begin
		if (arst_n && dst_valid && dst_ready)
			tracker.check_pair(dst_data);
	end

	// Watchdog: any transaction on either stream resets the count.
	always @(posedge clk) begin
		if (!arst_n || (src_valid && src_ready) || (dst_valid && dst_ready)) begin
			stall_count = 0;
		end else begin
			stall_count++;
			if (stall_count >= STALL_LIMIT) begin
				$display("watchdog: %0d cycles without a transaction", stall_count);
				$display("[feedback_echo_delay] ERROR");
				$finish;
			end
		end
	end

	// Receiver: random stall bursts, plus one long hold on request.
	initial begin
		dst_ready = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (hold_req) begin
				dst_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_req = 1'b0;
			end else if (snk_gap_pct != 0 && $urandom_range(0, 99) < snk_gap_pct) begin
				dst_ready <= 1'b0;
				repeat ($urandom_range(1, 13)) @(posedge clk);
			end
			dst_ready <= 1'b1;
			@(posedge clk);
		end
	end

	function automatic logic [APB_AW-1:0] reg_addr(fed_reg_t r);
		return APB_AW'(4 * int'(r));
	endfunction

	// Offer one sample pair and hold it until accepted. Returns on the accepting
	// edge, so the next call can drive new data in the same step without a dip in valid.
	task automatic send_item(input fed_in_t item);
		if (src_gap_pct != 0 && $urandom_range(0, 99) < src_gap_pct) begin
			src_valid <= 1'b0;
			repeat ($urandom_range(1, 13)) @(posedge clk);
		end
		src_valid <= 1'b1;
		src_data <= item;
		@(posedge clk);
		while (!src_ready)
			@(posedge clk);
		tracker.take_pair(item);
	endtask

	task automatic send_pair(input logic signed [SAMPLE_W-1:0] l,
			input logic signed [SAMPLE_W-1:0] r);
		fed_in_t item;
		item.left_in = l;
		item.right_in = r;
		send_item(item);
	endtask

	// APB write: setup, access, then idle with psel low so psel never toggles twice in a step
	task automatic reg_write(input logic [APB_AW-1:0] addr, input logic [APB_DW-1:0] data);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		tracker.set_reg(addr[APB_AW-1:2], data);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
	endtask

	task automatic reg_check(input fed_reg_t r, input logic [APB_DW-1:0] want);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= reg_addr(r);
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		if (prdata !== want) begin
			$error("prdata of %s expected %0d actual %0d", r.name(), want, prdata);
			reg_errors++;
		end
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic check_regs();
		reg_check(REG_DELAY, APB_DW'(tracker.dly_reg));
		reg_check(REG_GAIN, APB_DW'(tracker.gain_reg));
		reg_check(REG_LOWPASS, APB_DW'(tracker.lp_reg));
	endtask

	// Stop offering, let every predicted transaction come out, then let the pipe settle.
	task automatic drain();
		src_valid <= 1'b0;
		while (tracker.expected_pairs.size() != 0)
			@(posedge clk);
		repeat (PIPE_SETTLE) @(posedge clk);
	endtask

	// New register setting, written only with the block idle. Upper pwdata bits
	// carry junk that the block must drop.
	task automatic apply_config(input int dly, input int gain, input bit lp);
		logic [APB_DW-1:0] junk;
		drain();
		junk = $urandom();
		reg_write(reg_addr(REG_DELAY), (junk << DELAY_W) | APB_DW'(dly));
		junk = $urandom();
		reg_write(reg_addr(REG_GAIN), (junk << GAIN_W) | APB_DW'(gain));
		junk = $urandom();
		reg_write(reg_addr(REG_LOWPASS), (junk << 1) | APB_DW'(lp));
		check_regs();
		settings_applied++;
	endtask

	function automatic logic signed [SAMPLE_W-1:0] pick_sample();
		case ($urandom_range(0, 9))
			0: return 16'sh7fff;
			1: return 16'sh8000;
			2: return '0;
			3: return $urandom_range(0, 1) ? 16'sd1 : -16'sd1;
			4, 5: return SAMPLE_W'(int'($urandom_range(0, 400)) - 200);
			default: return SAMPLE_W'($urandom());
		endcase
	endfunction

	function automatic int pick_delay();
		case ($urandom_range(0, 9))
			0: return 0;
			1, 2: return $urandom_range(1, 3);
			3, 4, 5, 6, 7: return $urandom_range(4, 64);
			8: return $urandom_range(65, 2000);
			default: return $urandom_range(2001, 16383);
		endcase
	endfunction

	function automatic int pick_gain();
		case ($urandom_range(0, 9))
			0: return 0;
			1: return 255;
			default: return $urandom_range(0, 255);
		endcase
	endfunction

	// Random music-like stream: mostly arbitrary pairs, with runs of silence long
	// enough to drain short echoes and reach the all-zero path.
	task automatic send_stream(input int count);
		fed_in_t item;
		int sent;
		int run;
		sent = 0;
		while (sent < count) begin
			if ($urandom_range(0, 6) == 0) begin
				run = $urandom_range(1, 40);
				repeat (run) send_item('0);
				sent += run;
			end else begin
				item.left_in = pick_sample();
				item.right_in = pick_sample();
				send_item(item);
				sent++;
			end
		end
	endtask

	initial begin
		int dly, gain;
		bit lp;
		tracker = new();
		reg_errors = 0;
		settings_applied = 0;
		stall_count = 0;
		hold_req = 1'b0;
		src_gap_pct = 20;
		snk_gap_pct = 20;
		arst_n = 1'b0;
		src_valid = 1'b0;
		src_data = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// --- directed ---
		// reset values: delay 0, so the block is bypassed
		check_regs();
		send_pair(16'sh7fff, 16'sh8000);
		send_pair(16'sh8000, 16'sh7fff);
		send_pair('0, '0);
		send_pair(16'sd1, -16'sd1);

		// short delay at full feedback, lowpass off: saturation both ways
		apply_config(3, 255, 1'b0);
		repeat (4) send_pair(16'sh7fff, 16'sh7fff);
		repeat (3) send_pair(16'sh8000, 16'sh8000);
		send_pair(16'sh7fff, 16'sh8000);
		send_pair('0, '0);

		// delay of one with no feedback, lowpass on: silence path and tap decay
		apply_config(1, 0, 1'b1);
		send_pair('0, '0);
		send_pair(16'sd100, -16'sd50);
		send_pair(16'sh8000, 16'sh8000);
		repeat (5) send_pair('0, '0);
		send_pair(16'sh7fff, 16'sh7fff);
		send_pair('0, '0);

		// write to an index past the register list must change nothing
		drain();
		reg_write(APB_AW'(4 * 3), $urandom());
		check_regs();

		// --- random phases ---
		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			case (ph)
				0: begin
					dly = 16383;
					gain = 255;
					lp = 1'b1;
				end
				1: begin
					dly = 1;
					gain = 0;
					lp = 1'b0;
				end
				2: begin
					dly = 0;
					gain = pick_gain();
					lp = $urandom_range(0, 1);
				end
				default: begin
					dly = pick_delay();
					gain = pick_gain();
					lp = $urandom_range(0, 1);
				end
			endcase
			apply_config(dly, gain, lp);
			if (ph == RANDOM_PHASES - 1) begin
				// closing stretch runs flat out
				src_gap_pct = 0;
				snk_gap_pct = 0;
			end else if (ph == 3) begin
				// receiver holds off while the sender keeps pushing
				src_gap_pct = 0;
				snk_gap_pct = 0;
				hold_req = 1'b1;
			end else begin
				src_gap_pct = $urandom_range(0, 2) * 15;
				snk_gap_pct = $urandom_range(0, 2) * 15;
			end
			send_stream(PHASE_PAIRS);
		end

		drain();
		repeat (PIPE_SETTLE) @(posedge clk);
		$display("checked %0d output transactions across %0d register settings",
			tracker.checked, settings_applied);
		$display("%0d steps took the silence path, %0d register readback mismatches",
			tracker.zero_steps, reg_errors);
		if (tracker.errors == 0 && reg_errors == 0 && tracker.expected_pairs.size() == 0)
			$display("[feedback_echo_delay] OK");
		else
			$display("[feedback_echo_delay] ERROR");
		$finish;
	end

endmodule

@@ sim.f @@
rtl/core/fed_pkg.sv
rtl/core/fed_ram.sv
rtl/core/feedback_echo_delay.sv
test/feedback_echo_delay_test.sv
